// ----- sv/isort_pkg.sv -----
`timescale 1ns / 1ps

package isort_pkg;

  localparam int DATA_W = 32;
  localparam int MAX_ITEMS = 64;

  // What one cell shows to its neighbors.
  typedef struct packed {
    logic              valid;
    logic              gt;
    logic [DATA_W-1:0] value;
  } cell_link_t;

  // Controls shared by every cell of the chain.
  typedef struct packed {
    logic              insert;
    logic              shift;
    logic [DATA_W-1:0] value;
  } chain_ctrl_t;

endpackage

// ----- sv/isort_cell.sv -----
`timescale 1ns / 1ps

module isort_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  isort_pkg::chain_ctrl_t  ctrl,
  input  isort_pkg::cell_link_t   lower,
  input  isort_pkg::cell_link_t   upper,
  output isort_pkg::cell_link_t   link
);

  logic                         valid;
  logic [isort_pkg::DATA_W-1:0] value;
  logic                         gt;

  // Strictly greater entries move up, so equal values keep arrival order.
  assign gt = valid && (value > ctrl.value);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= upper.valid;
    end else if (ctrl.insert) begin
      valid <= valid | lower.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      value <= upper.value;
    end else if (ctrl.insert) begin
      if (lower.gt) begin
        value <= lower.value;
      end else if (lower.valid && (gt || !valid)) begin
        value <= ctrl.value;
      end
    end
  end

  assign link = '{valid: valid, gt: gt, value: value};

endmodule

// ----- sv/insertion_sorter.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Payload
// request   in         start & !busy      value, last_in
// result    out        strobe             sorted_value, last_out, dropped
//
// One request is taken per cycle while busy is low; each is inserted into the
// cell chain in the cycle it is accepted unless the chain is full, all cells comparing at once.
// After a request flagged last, busy rises and the set drains from cell 0 at
// one result per cycle, then busy falls.
// Reset is synchronous and empties the chain. Results cannot be stalled.

module insertion_sorter #(
  parameter int MAX_ITEMS = isort_pkg::MAX_ITEMS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [isort_pkg::DATA_W-1:0] value,
  input  logic                         last_in,
  output logic                         strobe,
  output logic [isort_pkg::DATA_W-1:0] sorted_value,
  output logic                         last_out,
  output logic                         dropped
);

  isort_pkg::cell_link_t  links [MAX_ITEMS];
  isort_pkg::chain_ctrl_t ctrl;
  logic [MAX_ITEMS-1:0]   cell_valid;
  logic                   draining;
  logic                   overflow_seen;
  logic                   accept;
  logic                   full;
  logic                   final_out;

  assign accept    = start && !draining;
  assign full      = links[MAX_ITEMS-1].valid;
  assign final_out = draining && !links[1].valid;
  assign busy      = draining;

  assign ctrl = '{insert: accept && !full, shift: draining, value: value};

  genvar i;
  generate
    for (i = 0; i < MAX_ITEMS; i++) begin : g_cell
      isort_pkg::cell_link_t lower_link;
      isort_pkg::cell_link_t upper_link;
      if (i == 0) begin : g_bottom
        assign lower_link = '{valid: 1'b1, gt: 1'b0, value: '0};
      end else begin : g_lower
        assign lower_link = links[i-1];
      end
      if (i == MAX_ITEMS - 1) begin : g_top
        assign upper_link = '{valid: 1'b0, gt: 1'b0, value: '0};
      end else begin : g_upper
        assign upper_link = links[i+1];
      end
      isort_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .ctrl  (ctrl),
        .lower (lower_link),
        .upper (upper_link),
        .link  (links[i])
      );
      assign cell_valid[i] = links[i].valid;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      draining      <= 1'b0;
      overflow_seen <= 1'b0;
      strobe        <= 1'b0;
    end else begin
      strobe <= draining;
      if (accept) begin
        if (full) begin
          overflow_seen <= 1'b1;
        end
        if (last_in) begin
          draining <= 1'b1;
        end
      end else if (final_out) begin
        draining      <= 1'b0;
        overflow_seen <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    sorted_value <= links[0].value;
    last_out     <= final_out;
    dropped      <= final_out && overflow_seen;
  end

  // Occupied cells always form one run starting at cell 0.
  assert property (@(posedge clk) disable iff (rst)
    (cell_valid & (cell_valid + MAX_ITEMS'(1))) == '0)
    else $error("cell chain has a gap");

  assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(draining))
    else $error("result without drain");

  assert property (@(posedge clk) disable iff (rst)
    (strobe && last_out) |=> !strobe)
    else $error("result after final result");

  assert property (@(posedge clk) disable iff (rst)
    draining |-> links[0].valid)
    else $error("drain from empty chain");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  typedef struct {
    logic [isort_pkg::DATA_W-1:0] val;
    logic                         last;
    bit                           hold;   // not a request: wait for the block to drain
  } sort_req_t;

  typedef struct {
    logic [isort_pkg::DATA_W-1:0] val;
    logic                         last;
    logic                         drop;
  } sorted_item_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         start = 1'b0;
  logic [isort_pkg::DATA_W-1:0] value = '0;
  logic                         last_in = 1'b0;
  logic                         busy;
  logic                         strobe;
  logic [isort_pkg::DATA_W-1:0] sorted_value;
  logic                         last_out;
  logic                         dropped;

  sort_req_t                    req_queue[$];
  sorted_item_t                 expected_sorted[$];
  logic [isort_pkg::DATA_W-1:0] shadow_store[$];
  bit                           shadow_overflow = 1'b0;
  int                           pending_results = 0;

  int err_count = 0;
  int accepted_n = 0;
  int set_count = 0;
  int drop_sets = 0;
  int result_count = 0;
  int longest_set = 0;

  insertion_sorter u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .value        (value),
    .last_in      (last_in),
    .strobe       (strobe),
    .sorted_value (sorted_value),
    .last_out     (last_out),
    .dropped      (dropped)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic queue_request(input logic [isort_pkg::DATA_W-1:0] v, input logic l,
                               input bit h);
    sort_req_t r;
    r.val = v;
    r.last = l;
    r.hold = h;
    req_queue.push_back(r);
  endtask

  // Driver: at most one assignment to start per edge, chosen after the acceptance check.
  bit hold_armed = 1'b0;
  always @(posedge clk) begin
    bit go;
    bit idle;
    go = 1'b0;
    if (rst) begin
      start <= 1'b0;
    end else if (start && busy) begin
      // Request still waiting to be taken; keep it on the ports.
    end else begin
      if (start) begin
        void'(req_queue.pop_front());
        accepted_n++;
      end
      if (req_queue.size() != 0) begin
        if (req_queue[0].hold) begin
          // The count of outstanding results is registered, so it lags; arm first.
          if (hold_armed && pending_results == 0 && !busy) begin
            void'(req_queue.pop_front());
            hold_armed = 1'b0;
          end else begin
            hold_armed = 1'b1;
          end
        end else begin
          idle = ($urandom_range(0, 99) < 34) && !(accepted_n >= 60 && accepted_n < 140);
          if (!idle) begin
            go = 1'b1;
            value <= req_queue[0].val;
            last_in <= req_queue[0].last;
          end
        end
      end
      start <= go;
    end
  end

  // Monitor: predicts from accepted requests, then checks any result this edge.
  always @(posedge clk) begin
    int pos;
    sorted_item_t exp_item;
    if (!rst) begin
      if (start && !busy) begin
        if (shadow_store.size() < isort_pkg::MAX_ITEMS) begin
          pos = shadow_store.size();
          while (pos > 0 && shadow_store[pos-1] > value) pos--;
          shadow_store.insert(pos, value);
        end else begin
          shadow_overflow = 1'b1;
        end
        if (last_in) begin
          for (int k = 0; k < shadow_store.size(); k++) begin
            exp_item.val = shadow_store[k];
            exp_item.last = (k == shadow_store.size() - 1);
            exp_item.drop = exp_item.last && shadow_overflow;
            expected_sorted.push_back(exp_item);
          end
          if (shadow_store.size() > longest_set) longest_set = shadow_store.size();
          if (shadow_overflow) drop_sets++;
          set_count++;
          shadow_store.delete();
          shadow_overflow = 1'b0;
        end
      end
      if (strobe) begin
        result_count++;
        if (expected_sorted.size() == 0) begin
          report_mismatch($sformatf("unexpected result value=%h last=%b dropped=%b",
                                    sorted_value, last_out, dropped));
        end else begin
          exp_item = expected_sorted.pop_front();
          if (sorted_value !== exp_item.val)
            report_mismatch($sformatf("sorted_value %h, want %h", sorted_value, exp_item.val));
          if (last_out !== exp_item.last)
            report_mismatch($sformatf("last_out %b, want %b", last_out, exp_item.last));
          if (dropped !== exp_item.drop)
            report_mismatch($sformatf("dropped %b, want %b", dropped, exp_item.drop));
        end
      end
    end
    pending_results <= expected_sorted.size();
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int gen_n;
    int set_idx;
    int len;
    int mode;
    logic [isort_pkg::DATA_W-1:0] v;

    // Single-entry sets at both ends of the range.
    queue_request(32'h0000_0000, 1'b1, 1'b0);
    queue_request(32'hFFFF_FFFF, 1'b1, 1'b0);
    // Extremes and the values around the sign bit.
    queue_request(32'hFFFF_FFFF, 1'b0, 1'b0);
    queue_request(32'h0000_0000, 1'b0, 1'b0);
    queue_request(32'h8000_0000, 1'b0, 1'b0);
    queue_request(32'h7FFF_FFFF, 1'b0, 1'b0);
    queue_request(32'h0000_0001, 1'b0, 1'b0);
    queue_request(32'hFFFF_FFFE, 1'b1, 1'b0);
    // Repeated values.
    queue_request(32'd5, 1'b0, 1'b0);
    queue_request(32'd5, 1'b0, 1'b0);
    queue_request(32'd3, 1'b0, 1'b0);
    queue_request(32'd5, 1'b0, 1'b0);
    queue_request(32'd3, 1'b1, 1'b0);
    // Already ascending, then fully descending.
    for (int i = 1; i <= 4; i++) queue_request(i, i == 4, 1'b0);
    for (int i = 4; i >= 1; i--) queue_request(i, i == 1, 1'b0);
    queue_request(32'hAAAA_AAAA, 1'b0, 1'b0);
    queue_request(32'h5555_5555, 1'b1, 1'b0);
    queue_request('0, 1'b0, 1'b1);

    // Random sets, mostly short, with one exactly full set and one that overflows.
    gen_n = 0;
    set_idx = 0;
    while (gen_n < 200) begin
      if (set_idx == 4) len = isort_pkg::MAX_ITEMS;
      else if (set_idx == 11) len = isort_pkg::MAX_ITEMS + $urandom_range(1, 4);
      else len = $urandom_range(1, 12);
      mode = $urandom_range(0, 2);
      for (int i = 0; i < len; i++) begin
        case (mode)
          0: v = $urandom;
          1: v = $urandom_range(0, 7);
          default: begin
            case ($urandom_range(0, 2))
              0: v = 32'h0000_0000;
              1: v = 32'hFFFF_FFFF;
              default: v = $urandom;
            endcase
          end
        endcase
        queue_request(v, i == len - 1, 1'b0);
      end
      gen_n += len;
      if ($urandom_range(0, 9) == 0) queue_request('0, 1'b0, 1'b1);
      set_idx++;
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (req_queue.size() != 0) @(posedge clk);
    while (expected_sorted.size() != 0) @(posedge clk);
    repeat (2 * isort_pkg::MAX_ITEMS + 10) @(posedge clk);

    if (expected_sorted.size() != 0)
      report_mismatch($sformatf("%0d expected results never came", expected_sorted.size()));

    $display("run covered %0d requests in %0d sets (longest %0d entries, %0d with drops)",
             accepted_n, set_count, longest_set, drop_sets);
    $display("%0d sorted results seen, %0d mismatches", result_count, err_count);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/isort_pkg.sv
sv/isort_cell.sv
sv/insertion_sorter.sv
verif/testbench.sv
